/* src/boc_pkg.sv */
package boc_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;
  localparam logic [5:0]  NO_SLOT = 6'(TABLE_DEPTH);
  localparam int          MCAST_BIT = 40;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_ADDR  = 3'd3,
    ST_BAD_SWEEP = 3'd4,
    ST_BAD_STATE = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CL_LOOKUP    = 2'd0,
    CL_BAD_ADDR  = 2'd1,
    CL_BAD_SWEEP = 2'd2
  } class_t;

  typedef struct packed {
    logic [47:0]        addr;
    logic signed [7:0]  sig;
    logic [31:0]        sweep;
    class_t             cls;
  } item_t;

  typedef struct packed {
    logic [47:0]        addr;
    logic signed [7:0]  strongest;
    logic [31:0]        orig_sweep;
    logic [31:0]        recent_sweep;
    logic [31:0]        obs;
  } entry_t;

endpackage

/* src/boc_front.sv */
module boc_front (
  input  logic                start,
  input  logic [47:0]         station_address,
  input  logic signed [7:0]   signal_strength,
  input  logic [31:0]         sweep_number,
  input  logic                q_full,
  output logic                busy,
  output logic                push,
  output boc_pkg::item_t      push_item
);
  import boc_pkg::*;

  assign busy = q_full;
  assign push = start && !q_full;

  // address checks first, then sweep
  always_comb begin
    push_item.addr  = station_address;
    push_item.sig   = signal_strength;
    push_item.sweep = sweep_number;
    if (station_address == 48'd0 || station_address[MCAST_BIT]) begin
      push_item.cls = CL_BAD_ADDR;
    end else if (sweep_number == 32'd0) begin
      push_item.cls = CL_BAD_SWEEP;
    end else begin
      push_item.cls = CL_LOOKUP;
    end
  end

endmodule

/* src/boc_queue.sv */
module boc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  boc_pkg::item_t  push_item,
  input  logic            pop,
  output boc_pkg::item_t  head,
  output logic            empty,
  output logic            full
);
  import boc_pkg::*;

  item_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

/* src/boc_back.sv */
module boc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  boc_pkg::item_t  q_head,
  output logic            pop,
  output logic            done,
  output logic [2:0]      status,
  output logic [5:0]      entry_index
);
  import boc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_UPDATE = 4'b0100,
    S_APPEND = 4'b1000
  } state_t;

  state_t             state, state_next;
  item_t              cur;
  entry_t             mem [TABLE_DEPTH];
  entry_t             rd_q;
  logic               rd_valid;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   hit_idx;
  logic [CNT_W-1:0]   scan_idx;
  logic [CNT_W-1:0]   used, used_next;
  logic [31:0]        dropped, dropped_next;
  logic               issue, hit;
  logic               res_fire;
  status_t            res_status;
  logic [5:0]         res_index;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  entry_t             wr_data;
  entry_t             new_rec, upd_rec;

  assign hit   = rd_valid && (rd_q.addr == cur.addr);
  assign issue = (state == S_SEARCH) && (scan_idx < used) && !hit;

  always_comb begin
    new_rec.addr         = cur.addr;
    new_rec.strongest    = cur.sig;
    new_rec.orig_sweep   = cur.sweep;
    new_rec.recent_sweep = cur.sweep;
    new_rec.obs          = 32'd1;

    upd_rec              = rd_q;
    upd_rec.strongest    = (cur.sig > rd_q.strongest) ? cur.sig : rd_q.strongest;
    upd_rec.recent_sweep = cur.sweep;
    upd_rec.obs          = rd_q.obs + 32'd1;
  end

  always_comb begin
    state_next   = state;
    pop          = 1'b0;
    res_fire     = 1'b0;
    res_status   = ST_INSERTED;
    res_index    = NO_SLOT;
    used_next    = used;
    dropped_next = dropped;
    wr_en        = 1'b0;
    wr_idx       = used[IDX_W-1:0];
    wr_data      = new_rec;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (q_head.cls)
            CL_BAD_ADDR: begin
              res_fire   = 1'b1;
              res_status = ST_BAD_ADDR;
            end
            CL_BAD_SWEEP: begin
              res_fire   = 1'b1;
              res_status = ST_BAD_SWEEP;
            end
            CL_LOOKUP: state_next = S_SEARCH;
            default:   state_next = S_SEARCH;
          endcase
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_next = S_UPDATE;
        end else if (!issue && !rd_valid) begin
          state_next = S_APPEND;
        end
      end
      S_UPDATE: begin
        res_fire   = 1'b1;
        state_next = S_IDLE;
        if (cur.sweep < rd_q.recent_sweep) begin
          res_status = ST_BAD_SWEEP;
        end else if (rd_q.obs == U32_MAX) begin
          res_status = ST_BAD_STATE;
        end else begin
          res_status = ST_UPDATED;
          res_index  = 6'(hit_idx);
          wr_en      = 1'b1;
          wr_idx     = hit_idx;
          wr_data    = upd_rec;
        end
      end
      S_APPEND: begin
        res_fire   = 1'b1;
        state_next = S_IDLE;
        if (used == CNT_W'(TABLE_DEPTH)) begin
          if (dropped == U32_MAX) begin
            res_status = ST_BAD_STATE;
          end else begin
            res_status   = ST_FULL;
            dropped_next = dropped + 32'd1;
          end
        end else begin
          res_status = ST_INSERTED;
          res_index  = 6'(used);
          wr_en      = 1'b1;
          used_next  = used + 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      rd_valid <= 1'b0;
      scan_idx <= '0;
      used     <= '0;
      dropped  <= '0;
    end else begin
      state    <= state_next;
      done     <= res_fire;
      rd_valid <= issue;
      used     <= used_next;
      dropped  <= dropped_next;
      if (state == S_IDLE) begin
        scan_idx <= '0;
      end else if (issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
    if (res_fire) begin
      status      <= res_status;
      entry_index <= res_index;
    end
    if (issue) begin
      rd_idx <= scan_idx[IDX_W-1:0];
    end
    if (hit && state == S_SEARCH) begin
      hit_idx <= rd_idx;
    end
  end

  // entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (issue) begin
      rd_q <= mem[scan_idx[IDX_W-1:0]];
    end
  end

endmodule

/* src/bssid_observation_catalog_unit.sv */
// Station address catalog: one observation item in, one status item out.
// Input channel: an item (station_address, signal_strength, sweep_number) is
// taken at a rising edge with start high and busy low. busy only rises when
// the two-entry item queue between front and back is full.
// Output channel: done pulses for one cycle with status and entry_index;
// results leave in input order, exactly one per item. The receiver cannot
// stall, so the back end never waits on it.
// A bad address or zero sweep is reported without a table search once the
// back end is idle. A lookup scans the used entries one per cycle through
// the entry memory's registered read port, then goes to an update or append
// state; the table holds up to 32 entries. The back end takes the next item
// only after the last one is reported, so that scan sets the item rate.
// Reset (synchronous, rst high): table empty, dropped counter zero, queue
// empty. Entry contents are not cleared; only entries below the fill count
// are ever read.
module bssid_observation_catalog_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [47:0]        station_address,
  input  logic signed [7:0]  signal_strength,
  input  logic [31:0]        sweep_number,
  output logic               done,
  output logic [2:0]         status,
  output logic [5:0]         entry_index
);
  import boc_pkg::*;

  logic   q_full, q_empty;
  logic   push, pop;
  item_t  push_item, q_head;

  // front: classify address and sweep at acceptance
  boc_front u_front (
    .start           (start),
    .station_address (station_address),
    .signal_strength (signal_strength),
    .sweep_number    (sweep_number),
    .q_full          (q_full),
    .busy            (busy),
    .push            (push),
    .push_item       (push_item)
  );

  // short item queue decoupling front and back
  boc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // back: search, update or append, report
  boc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .pop         (pop),
    .done        (done),
    .status      (status),
    .entry_index (entry_index)
  );

  // slot index is real only for inserted and updated items
  a_slot_valid: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_INSERTED || status == ST_UPDATED)
      |-> entry_index < NO_SLOT)
    else $error("slot index out of range on insert/update");

  a_no_slot: assert property (@(posedge clk) disable iff (rst)
    done && !(status == ST_INSERTED || status == ST_UPDATED)
      |-> entry_index == NO_SLOT)
    else $error("rejected item carries a slot index");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= ST_BAD_STATE)
    else $error("undefined status code");

  // nothing can be popped from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
